@@ sv/assert_macros.svh @@
// Assertion macros shared by the sorter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DESX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define DESX_NEVER(lbl, clk, rstn, expr, msg) \
  `DESX_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

@@ sv/desx_pkg.sv @@
// Shared types for the descending exchange sorter.
// No dependencies.
`default_nettype none

package desx_pkg;

  // control from the sequencer to the exchange datapath
  typedef struct packed {
    logic load;  // capture read entry as the held entry
    logic cmp;   // compare read entry against held, swap on greater key
  } xchg_ctrl_t;

endpackage

`default_nettype wire

@@ sv/desx_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module desx_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/desx_xchg.sv @@
// Exchange datapath: held entry register and the shared key comparator.
// Depends on desx_pkg.
`default_nettype none

module desx_xchg #(
  parameter int KEY_WIDTH = 33,
  parameter int TAG_WIDTH = 16
) (
  input  wire logic                  clk,
  input  desx_pkg::xchg_ctrl_t       ctrl,
  input  wire logic [KEY_WIDTH-1:0]  rd_key,
  input  wire logic [TAG_WIDTH-1:0]  rd_tag,
  output logic                       swap,
  output logic      [KEY_WIDTH-1:0]  held_key,
  output logic      [TAG_WIDTH-1:0]  held_tag
);

  logic [KEY_WIDTH-1:0] held_key_r;
  logic [TAG_WIDTH-1:0] held_tag_r;

  assign swap     = ctrl.cmp && (held_key_r < rd_key);
  assign held_key = held_key_r;
  assign held_tag = held_tag_r;

  always_ff @(posedge clk) begin
    if (ctrl.load || swap) begin
      held_key_r <= rd_key;
      held_tag_r <= rd_tag;
    end
  end

endmodule

`default_nettype wire

@@ sv/descending_key_exchange_sorter.sv @@
// Descending exchange sorter: loads a set of entries into a RAM, sorts them by
// key in descending order with one shared comparator, then streams them out.
// An entry is accepted whenever in_valid is high while loading. After the last
// entry of a set, each sort row holds one stored entry and compares it with
// every later entry, one compare per cycle as set by the single RAM read port
// feeding the one comparator. Results then stream out one at a time, each held
// until taken. in_ready stays low from the last entry until the final result
// of the set is taken. Entries past MAX_ENTRIES are dropped and flagged in
// out_overflow on every result of that set.
// Depends on desx_pkg, desx_ram, desx_xchg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module descending_key_exchange_sorter #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_WIDTH   = 33,
  parameter int TAG_WIDTH   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KEY_WIDTH-1:0] in_entry_key,
  input  wire logic [TAG_WIDTH-1:0] in_entry_tag,
  input  wire logic                 in_last_entry,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [KEY_WIDTH-1:0] out_sorted_key,
  output logic      [TAG_WIDTH-1:0] out_sorted_tag,
  output logic                      out_last_result,
  output logic                      out_overflow
);

  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W  = $clog2(MAX_ENTRIES);
  localparam int ENTRY_W = KEY_WIDTH + TAG_WIDTH;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_LDI   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WRI   = 3'd4;
  localparam logic [2:0] S_OUTRD = 3'd5;
  localparam logic [2:0] S_OUTLD = 3'd6;
  localparam logic [2:0] S_OUTWT = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [KEY_WIDTH-1:0] out_key_r;
  logic [TAG_WIDTH-1:0] out_tag_r;
  logic                 out_last_r;
  logic                 out_ovf_r;
  logic                 out_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [CNT_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  desx_pkg::xchg_ctrl_t xctrl;
  logic                 swap;
  logic [KEY_WIDTH-1:0] held_key;
  logic [TAG_WIDTH-1:0] held_tag;

  logic             in_acc;
  logic             room;
  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W-1:0] j_inc;
  logic [CNT_W-1:0] i_inc2;
  logic [CNT_W-1:0] k_inc;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign room      = (cnt_r < CNT_W'(MAX_ENTRIES));
  assign cnt_after = room ? cnt_r + 1'b1 : cnt_r;
  assign j_inc     = j_r + 1'b1;
  assign i_inc2    = i_r + CNT_W'(2);
  assign k_inc     = k_r + 1'b1;

  desx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  desx_xchg #(
    .KEY_WIDTH (KEY_WIDTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_xchg (
    .clk      (clk),
    .ctrl     (xctrl),
    .rd_key   (ram_rdata[ENTRY_W-1:TAG_WIDTH]),
    .rd_tag   (ram_rdata[TAG_WIDTH-1:0]),
    .swap     (swap),
    .held_key (held_key),
    .held_tag (held_tag)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    xctrl         = '0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_wdata     = {held_key, held_tag};
    ram_raddr     = k_r;
    case (state_r)
      S_LOAD: begin
        ram_wdata = {in_entry_key, in_entry_tag};
        if (in_acc) begin
          ram_we      = room;
          cnt_nxt     = cnt_after;
          dropped_nxt = dropped_r || !room;
          if (in_last_entry) begin
            i_nxt = '0;
            j_nxt = CNT_W'(1);
            k_nxt = '0;
            if (cnt_after > CNT_W'(1)) begin
              state_nxt = S_RDI;
            end else begin
              state_nxt = S_OUTRD;
            end
          end
        end
      end
      S_RDI: begin
        ram_raddr = i_r;
        state_nxt = S_LDI;
      end
      S_LDI: begin
        xctrl.load = 1'b1;
        ram_raddr  = j_r;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        xctrl.cmp = 1'b1;
        ram_we    = swap;
        ram_waddr = j_r[ADDR_W-1:0];
        ram_raddr = j_inc;
        j_nxt     = j_inc;
        if (j_inc >= cnt_r) begin
          state_nxt = S_WRI;
        end
      end
      S_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[ADDR_W-1:0];
        i_nxt     = i_r + 1'b1;
        j_nxt     = i_inc2;
        if (i_inc2 < cnt_r) begin
          state_nxt = S_RDI;
        end else begin
          state_nxt = S_OUTRD;
        end
      end
      S_OUTRD: begin
        state_nxt = S_OUTLD;
      end
      S_OUTLD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        k_nxt         = k_inc;
        state_nxt     = S_OUTWT;
      end
      S_OUTWT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt     = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_OUTLD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r  <= ram_rdata[ENTRY_W-1:TAG_WIDTH];
      out_tag_r  <= ram_rdata[TAG_WIDTH-1:0];
      out_last_r <= (k_inc == cnt_r);
      out_ovf_r  <= dropped_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sorted_key  = out_key_r;
  assign out_sorted_tag  = out_tag_r;
  assign out_last_result = out_last_r;
  assign out_overflow    = out_ovf_r;

  `DESX_NEVER(a_load_vs_out, clk, rst_n, in_ready && out_valid, "load while result pending")
  `DESX_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_W'(MAX_ENTRIES), "entry count past capacity")
  `DESX_NEVER(a_cmp_range, clk, rst_n, (state_r == S_CMP) && (j_r >= cnt_r),
              "compare index out of set")
  `DESX_ASSERT(a_last_reopens, clk, rst_n,
               out_valid && out_ready && out_last_result |=> in_ready,
               "set end did not reopen input")

endmodule

`default_nettype wire

@@ verif/tb_descending_key_exchange_sorter.sv @@
// Self-checking bench for descending_key_exchange_sorter: sends sets of entries,
// predicts each sorted set locally and checks every result in order.
// Depends on the descending_key_exchange_sorter RTL only.
`timescale 1ns / 100ps

module tb_descending_key_exchange_sorter;

  localparam int KW          = 33;
  localparam int TW          = 16;
  localparam int CAP         = 64;
  localparam int ITEM_TARGET = 470;
  localparam int HOLD_CYCLES = 2500;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [KW-1:0] KEY_MAX = {KW{1'b1}};
  localparam logic [TW-1:0] TAG_MAX = {TW{1'b1}};

  typedef struct {
    logic [KW-1:0] key;
    logic [TW-1:0] tag;
    logic          last;
    logic          ovf;
  } sorted_entry_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [KW-1:0] in_entry_key;
  logic [TW-1:0] in_entry_tag;
  logic          in_last_entry;
  logic          out_valid;
  logic          out_ready;
  logic [KW-1:0] out_sorted_key;
  logic [TW-1:0] out_sorted_tag;
  logic          out_last_result;
  logic          out_overflow;

  sorted_entry_t pending_sorted[$];
  logic [KW-1:0] held_key [CAP];
  logic [TW-1:0] held_tag [CAP];
  int            held_cnt;
  logic          held_drop;

  int errors;
  int entries_sent;
  int burst_left;
  int cycle_cnt;
  int rx_cnt;
  int hold_req;
  int hold_ack;
  int hold_left;

  descending_key_exchange_sorter #(
    .MAX_ENTRIES(CAP),
    .KEY_WIDTH  (KW),
    .TAG_WIDTH  (TW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_key   (in_entry_key),
    .in_entry_tag   (in_entry_tag),
    .in_last_entry  (in_last_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sorted_key (out_sorted_key),
    .out_sorted_tag (out_sorted_tag),
    .out_last_result(out_last_result),
    .out_overflow   (out_overflow)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // store one accepted entry; a closing entry sorts the set and queues its results
  task automatic record_entry(input logic [KW-1:0] key, input logic [TW-1:0] tag,
                              input logic last);
    sorted_entry_t r;
    logic [KW-1:0] k;
    logic [TW-1:0] t;
    if (held_cnt < CAP) begin
      held_key[held_cnt] = key;
      held_tag[held_cnt] = tag;
      held_cnt++;
    end else begin
      held_drop = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < held_cnt; i++) begin
        for (int j = i + 1; j < held_cnt; j++) begin
          if (held_key[i] < held_key[j]) begin
            k = held_key[i];
            t = held_tag[i];
            held_key[i] = held_key[j];
            held_tag[i] = held_tag[j];
            held_key[j] = k;
            held_tag[j] = t;
          end
        end
      end
      for (int i = 0; i < held_cnt; i++) begin
        r.key  = held_key[i];
        r.tag  = held_tag[i];
        r.last = (i == held_cnt - 1);
        r.ovf  = held_drop;
        pending_sorted.push_back(r);
      end
      held_cnt  = 0;
      held_drop = 1'b0;
    end
  endtask

  // one request per entry, sent in bursts with random gaps
  task automatic send_entry(input logic [KW-1:0] key, input logic [TW-1:0] tag,
                            input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_entry_key  <= key;
    in_entry_tag  <= tag;
    in_last_entry <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    record_entry(key, tag, last);
    entries_sent++;
    @(negedge clk);
  endtask

  function automatic logic [KW-1:0] rand_key();
    logic        hi;
    logic [31:0] lo;
    int          sel;
    sel = $urandom_range(0, 15);
    hi  = 1'($urandom_range(0, 1));
    lo  = $urandom();
    if (sel == 0) return '0;
    if (sel == 1) return KEY_MAX;
    if (sel < 6) return KW'($urandom_range(100, 103));
    return {hi, lo};
  endfunction

  function automatic logic [TW-1:0] rand_tag();
    logic [TW-1:0] t;
    int            sel;
    sel = $urandom_range(0, 9);
    t   = TW'($urandom());
    if (sel == 0) return '0;
    if (sel == 1) return TAG_MAX;
    return t;
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_entry(rand_key(), rand_tag(), i == n - 1);
  endtask

  task automatic test_single_entry;
    send_entry(KEY_MAX, TAG_MAX, 1'b1);
    send_entry('0, '0, 1'b1);
  endtask

  task automatic test_key_extremes;
    send_entry('0, 16'h0001, 1'b0);
    send_entry(KEY_MAX, 16'h0002, 1'b0);
    send_entry(KW'(1), 16'h0003, 1'b0);
    send_entry(KEY_MAX - 1, 16'h0004, 1'b0);
    send_entry({1'b1, 32'h0}, TAG_MAX, 1'b0);
    send_entry({1'b0, 32'hffff_ffff}, '0, 1'b1);
  endtask

  task automatic test_key_ties;
    send_entry(KW'(500), 16'h00a0, 1'b0);
    send_entry(KW'(500), 16'h00a1, 1'b0);
    send_entry(KW'(900), 16'h00a2, 1'b0);
    send_entry(KW'(500), 16'h00a3, 1'b0);
    send_entry(KW'(900), 16'h00a4, 1'b0);
    send_entry(KW'(500), 16'h00a5, 1'b0);
    send_entry(KW'(20), 16'h00a6, 1'b1);
  endtask

  task automatic test_full_capacity;
    send_set(CAP);
  endtask

  task automatic test_overflow;
    send_set(CAP + 1);
    send_set(CAP + 6);
  endtask

  // receiver holds off while the sender keeps offering; input must stall
  task automatic test_output_backpressure;
    hold_req++;
    send_set(8);
    send_set(6);
  endtask

  task automatic test_random_sets;
    int n;
    while (entries_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(CAP - 2, CAP + 3);
        1, 2:    n = $urandom_range(13, 30);
        default: n = $urandom_range(1, 12);
      endcase
      send_set(n);
    end
  endtask

  always @(negedge clk) begin
    rx_cnt++;
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cnt / 256) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_cnt % 8 != 5);
      endcase
    end
  end

  always @(posedge clk) begin
    sorted_entry_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: key %h tag %h", out_sorted_key, out_sorted_tag);
        errors++;
      end else begin
        e = pending_sorted.pop_front();
        if (out_sorted_key !== e.key) begin
          $error("sorted_key: expected %h, actual %h", e.key, out_sorted_key);
          errors++;
        end
        if (out_sorted_tag !== e.tag) begin
          $error("sorted_tag: expected %h, actual %h", e.tag, out_sorted_tag);
          errors++;
        end
        if (out_last_result !== e.last) begin
          $error("last_result: expected %b, actual %b", e.last, out_last_result);
          errors++;
        end
        if (out_overflow !== e.ovf) begin
          $error("overflow: expected %b, actual %b", e.ovf, out_overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    errors        = 0;
    entries_sent  = 0;
    burst_left    = 0;
    cycle_cnt     = 0;
    rx_cnt        = 0;
    hold_req      = 0;
    hold_ack      = 0;
    hold_left     = 0;
    held_cnt      = 0;
    held_drop     = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_entry_key  = '0;
    in_entry_tag  = '0;
    in_last_entry = 1'b0;
    out_ready     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_entry;
    test_key_extremes;
    test_key_ties;
    test_full_capacity;
    test_overflow;
    test_output_backpressure;
    test_random_sets;

    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_sorted.size() != 0) begin
      $error("%0d sorted results never arrived", pending_sorted.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
